/* sv/rqd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-queue dispatcher package
// Shared field widths, event codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package rqd_pkg;

    localparam int FUNC_W            = 2;
    localparam int ID_W              = 4;
    localparam int PRIO_IN_W         = 8;
    localparam int COUNT_W           = 5;
    localparam int S_TDATA_W         = 16;
    localparam int M_TDATA_W         = 24;
    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_PRIORITY_BITS = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQUEUE  = 2'd0,
        FUNC_DISPATCH = 2'd1,
        FUNC_YIELD    = 2'd2,
        FUNC_BLOCK    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_START,
        ST_INS_SCAN,
        ST_INS_HEAD,
        ST_DISP,
        ST_DISP_POP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 dropped;
        logic [COUNT_W-1:0]   queue_count;
        logic [PRIO_IN_W-1:0] running_priority;
        logic [ID_W-1:0]      running_id;
        logic                 running_valid;
    } res_t;

endpackage

/* sv/rqd_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-queue entry memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rqd_mem #(
    parameter int DEPTH  = rqd_pkg::DEF_QUEUE_DEPTH,
    parameter int DATA_W = rqd_pkg::ID_W + rqd_pkg::DEF_PRIORITY_BITS
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/rqd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-queue sequencer
// Holds head, fill and running slot; drives the entry memory for sorted
// insert (tail-first scan and shift) and head pop.
// ----------------------------------------------------------------------------
module rqd_ctrl #(
    parameter int QUEUE_DEPTH   = rqd_pkg::DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = rqd_pkg::DEF_PRIORITY_BITS
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  rqd_pkg::func_t                              in_func,
    input  logic [rqd_pkg::ID_W-1:0]                    in_id,
    input  logic [rqd_pkg::PRIO_IN_W-1:0]               in_prio,
    output logic                                        res_valid,
    input  logic                                        res_ready,
    output rqd_pkg::res_t                               res,
    output logic                                        mem_wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]              mem_wr_addr,
    output logic [rqd_pkg::ID_W+PRIORITY_BITS-1:0]      mem_wr_data,
    output logic                                        mem_rd_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]              mem_rd_addr,
    input  logic [rqd_pkg::ID_W+PRIORITY_BITS-1:0]      mem_rd_data
);

    import rqd_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam int ENT_W = ID_W + PRIORITY_BITS;

    state_t                   state_reg, state_next;
    func_t                    func_reg, func_next;
    logic [ID_W-1:0]          ins_id_reg, ins_id_next;
    logic [PRIORITY_BITS-1:0] ins_prio_reg, ins_prio_next;
    logic                     drop_reg, drop_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [IDX_W-1:0]         head_reg, head_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic                     run_valid_reg, run_valid_next;
    logic [ID_W-1:0]          run_id_reg, run_id_next;
    logic [PRIORITY_BITS-1:0] run_prio_reg, run_prio_next;

    logic [PRIORITY_BITS-1:0] in_prio_k;
    logic [PRIO_IN_W-1:0]     run_prio_out;
    logic [COUNT_W-1:0]       fill_out;
    logic [ID_W-1:0]          rd_id;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [ENT_W-1:0]         ins_entry;
    logic                     full;
    logic                     fill_zero;
    logic                     hit;
    logic                     last;

    // Map a queue offset onto a memory address relative to the head.
    function automatic logic [IDX_W-1:0] off_addr(input logic [IDX_W-1:0] head,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Keep the low PRIORITY_BITS of the incoming priority, and the reverse on output.
    for (genvar g = 0; g < PRIORITY_BITS; g++)
    begin : g_prio_in
        if (g < PRIO_IN_W)
        begin : g_bit
            assign in_prio_k[g] = in_prio[g];
        end
        else
        begin : g_zero
            assign in_prio_k[g] = 1'b0;
        end
    end

    for (genvar g = 0; g < PRIO_IN_W; g++)
    begin : g_prio_out
        if (g < PRIORITY_BITS)
        begin : g_bit
            assign run_prio_out[g] = run_prio_reg[g];
        end
        else
        begin : g_zero
            assign run_prio_out[g] = 1'b0;
        end
    end

    for (genvar g = 0; g < COUNT_W; g++)
    begin : g_count_out
        if (g < CNT_W)
        begin : g_bit
            assign fill_out[g] = fill_reg[g];
        end
        else
        begin : g_zero
            assign fill_out[g] = 1'b0;
        end
    end

    assign rd_id     = mem_rd_data[ID_W-1:0];
    assign rd_prio   = mem_rd_data[ENT_W-1:ID_W];
    assign ins_entry = {ins_prio_reg, ins_id_reg};
    assign full      = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign fill_zero = (fill_reg == '0);
    assign hit       = (rd_prio >= ins_prio_reg);
    assign last      = (k_reg == '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (in_func == FUNC_ENQUEUE)
                        state_next = full ? ST_DONE : ST_INS_START;
                    else if (in_func == FUNC_YIELD && run_valid_reg && !full)
                        state_next = ST_INS_START;
                    else
                        state_next = ST_DISP;
                end
            end
            ST_INS_START:
            begin
                if (fill_zero)
                    state_next = (func_reg == FUNC_YIELD) ? ST_DISP : ST_DONE;
                else
                    state_next = ST_INS_SCAN;
            end
            ST_INS_SCAN:
            begin
                if (hit)
                    state_next = (func_reg == FUNC_YIELD) ? ST_DISP : ST_DONE;
                else if (last)
                    state_next = ST_INS_HEAD;
            end
            ST_INS_HEAD:
            begin
                state_next = (func_reg == FUNC_YIELD) ? ST_DISP : ST_DONE;
            end
            ST_DISP:
            begin
                state_next = fill_zero ? ST_DONE : ST_DISP_POP;
            end
            ST_DISP_POP:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and memory port
    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        res_valid   = (state_reg == ST_DONE);
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = ins_entry;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        unique case (state_reg)
            ST_INS_START:
            begin
                if (fill_zero)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = head_reg;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = off_addr(head_reg, fill_reg - CNT_W'(1));
                end
            end
            ST_INS_SCAN:
            begin
                // Place the new entry behind this one, or shift this one up.
                mem_wr_en   = 1'b1;
                mem_wr_addr = off_addr(head_reg, k_reg + CNT_W'(1));
                if (!hit)
                begin
                    mem_wr_data = mem_rd_data;
                    if (!last)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = off_addr(head_reg, k_reg - CNT_W'(1));
                    end
                end
            end
            ST_INS_HEAD:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = head_reg;
            end
            ST_DISP:
            begin
                mem_rd_en   = !fill_zero;
                mem_rd_addr = head_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        func_next      = func_reg;
        ins_id_next    = ins_id_reg;
        ins_prio_next  = ins_prio_reg;
        drop_next      = drop_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        k_next         = k_reg;
        run_valid_next = run_valid_reg;
        run_id_next    = run_id_reg;
        run_prio_next  = run_prio_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next     = in_func;
                    ins_id_next   = in_id;
                    ins_prio_next = in_prio_k;
                    drop_next     = 1'b0;
                    if (in_func == FUNC_ENQUEUE)
                    begin
                        drop_next = full;
                    end
                    else if (in_func == FUNC_YIELD)
                    begin
                        ins_id_next   = run_id_reg;
                        ins_prio_next = run_prio_reg;
                        drop_next     = run_valid_reg && full;
                    end
                end
            end
            ST_INS_START:
            begin
                if (fill_zero)
                    fill_next = fill_reg + CNT_W'(1);
                else
                    k_next = fill_reg - CNT_W'(1);
            end
            ST_INS_SCAN:
            begin
                if (hit)
                    fill_next = fill_reg + CNT_W'(1);
                else
                    k_next = k_reg - CNT_W'(1);
            end
            ST_INS_HEAD:
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
            ST_DISP:
            begin
                if (fill_zero)
                begin
                    run_valid_next = 1'b0;
                    run_id_next    = '0;
                    run_prio_next  = '0;
                end
            end
            ST_DISP_POP:
            begin
                run_valid_next = 1'b1;
                run_id_next    = rd_id;
                run_prio_next  = rd_prio;
                fill_next      = fill_reg - CNT_W'(1);
                head_next      = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : head_reg + IDX_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            drop_reg      <= 1'b0;
            fill_reg      <= '0;
            head_reg      <= '0;
            run_valid_reg <= 1'b0;
            run_id_reg    <= '0;
            run_prio_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            drop_reg      <= drop_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            run_valid_reg <= run_valid_next;
            run_id_reg    <= run_id_next;
            run_prio_reg  <= run_prio_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        ins_id_reg   <= ins_id_next;
        ins_prio_reg <= ins_prio_next;
        k_reg        <= k_next;
    end

    assign res.running_valid    = run_valid_reg;
    assign res.running_id       = run_id_reg;
    assign res.running_priority = run_prio_out;
    assign res.queue_count      = fill_out;
    assign res.dropped          = drop_reg;

endmodule

/* sv/priority_ready_queue_dispatcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority ready-queue dispatcher
// Thread run queue sorted by priority (FIFO among equals) with a running slot.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake            Payload
//  --------  ----  -------------------  -------------------------------------
//  s_*       in    s_tvalid / s_tready  tuser: func; tdata: thread_id, priority
//  m_*       out   m_tvalid / m_tready  tdata: running slot, queue count, drop
//
//  Sequencing: one event at a time, held from acceptance until its result
//  is taken into the result register. Dispatch and block pop the head entry
//  into the running slot, or clear the slot on an empty queue; an enqueue
//  shifts every waiting entry of lower priority up by one place.
//  Yield with a thread running and room in the queue is the insert of the
//  running thread followed by a dispatch; otherwise it is a dispatch alone.
//  The pace is set by the entry memory, with one read port and one write
//  port, scanned from the tail.
//  Reset: queue empty, nothing running; the entry memory is not cleared.
//  Stalls: a held result does not stop the next event being accepted; the
//  sequencer waits only when it has a new result and the output is still full.
//
module priority_ready_queue_dispatcher #(
    parameter int QUEUE_DEPTH   = rqd_pkg::DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = rqd_pkg::DEF_PRIORITY_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [3:0] thread_id, [11:4] thread_priority, [15:12] zero
    input  logic [rqd_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] func
    input  logic [rqd_pkg::FUNC_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] running_valid, [4:1] running_id, [12:5] running_priority,
    // [17:13] queue_count, [18] dropped, [23:19] zero
    output logic [rqd_pkg::M_TDATA_W-1:0] m_tdata
);

    import rqd_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int ENT_W = ID_W + PRIORITY_BITS;
    localparam int RES_W = $bits(res_t);

    logic             res_valid;
    logic             res_ready;
    res_t             res;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [ENT_W-1:0] mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    logic [ENT_W-1:0] mem_rd_data;

    logic             m_tvalid_reg;
    res_t             m_res_reg;

    rqd_ctrl #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_func     (func_t'(s_tuser)),
        .in_id       (s_tdata[ID_W-1:0]),
        .in_prio     (s_tdata[ID_W+PRIO_IN_W-1:ID_W]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    rqd_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (ENT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register: free when empty or being drained this cycle.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    // Hold the result while the consumer stalls.
    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - RES_W)'(0), m_res_reg};

endmodule

/* sv/rqd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run-queue dispatcher port checker
// Watches the top-level ports; bound to every instance of the dispatcher.
// ----------------------------------------------------------------------------
module rqd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [rqd_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [rqd_pkg::FUNC_W-1:0]    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rqd_pkg::M_TDATA_W-1:0] m_tdata
);

    import rqd_pkg::*;

    // One event in flight: the sequencer leaves idle straight after acceptance.
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("dispatcher accepted two events back to back");

    // Nothing running reports a zero id and priority.
    a_idle_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[12:1] == 12'd0))
        else $error("empty running slot reports a thread");

    // Padding above the packed fields stays clear.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:19] == '0))
        else $error("result padding bits set");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

bind priority_ready_queue_dispatcher rqd_checker u_rqd_checker (.*);
